### rtl/cgld_pkg.sv
// ----------------------------------------------------------------------------
// cgld_pkg
// Shared types, constants and the microcode table of the character grid line
// drawer.
// ----------------------------------------------------------------------------
package cgld_pkg;

  localparam int MAX_COLUMNS_DEF = 128;
  localparam int MAX_ROWS_DEF    = 64;
  localparam int GLYPH_BITS_DEF  = 32;

  localparam int COORD_W  = 11;
  localparam int VALUE_W  = 32;
  localparam int CMD_W    = 2;
  localparam int WIDTH_W  = 8;
  localparam int HEIGHT_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int IN_DATA_W  = 80;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 8'd80;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 7'd24;
  localparam logic [63:0]         SPACE_CODE = 64'h20;

  localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  typedef logic [3:0] step_t;

  localparam step_t S_CLEAR       = 4'd0;
  localparam step_t S_IDLE        = 4'd1;
  localparam step_t S_DISPATCH    = 4'd2;
  localparam step_t S_DISPATCH_WR = 4'd3;
  localparam step_t S_DISPATCH_RD = 4'd4;
  localparam step_t S_UNUSED      = 4'd5;
  localparam step_t S_DRAW_CHK    = 4'd6;
  localparam step_t S_DRAW        = 4'd7;
  localparam step_t S_SKIP        = 4'd8;
  localparam step_t S_WRITE       = 4'd9;
  localparam step_t S_READ        = 4'd10;
  localparam step_t S_READ_WAIT   = 4'd11;
  localparam step_t S_READ_TAKE   = 4'd12;
  localparam step_t S_EMIT        = 4'd13;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_ACCEPT,
    C_CMD_DRAW,
    C_CMD_WRITE,
    C_CMD_READ,
    C_BOTH_OFF,
    C_AT_END,
    C_CLEAR_LAST,
    C_OUT_FREE
  } cond_e;

  typedef struct packed {
    logic  accept;
    logic  clear_wr;
    logic  plot;
    logic  brs_step;
    logic  init_err;
    logic  set_skip;
    logic  rd_issue;
    logic  take_rd;
    logic  emit;
    cond_e cond;
    logic  stay;
    step_t target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    w = '0;
    unique case (s)
      S_CLEAR: begin
        w.clear_wr = 1'b1; w.cond = C_CLEAR_LAST; w.stay = 1'b1; w.target = S_IDLE;
      end
      S_IDLE: begin
        w.accept = 1'b1; w.cond = C_ACCEPT; w.stay = 1'b1; w.target = S_DISPATCH;
      end
      S_DISPATCH: begin
        w.cond = C_CMD_DRAW; w.target = S_DRAW_CHK;
      end
      S_DISPATCH_WR: begin
        w.cond = C_CMD_WRITE; w.target = S_WRITE;
      end
      S_DISPATCH_RD: begin
        w.cond = C_CMD_READ; w.target = S_READ;
      end
      S_UNUSED: begin
        w.cond = C_ALWAYS; w.target = S_EMIT;
      end
      S_DRAW_CHK: begin
        w.init_err = 1'b1; w.cond = C_BOTH_OFF; w.target = S_SKIP;
      end
      S_DRAW: begin
        w.plot = 1'b1; w.brs_step = 1'b1; w.cond = C_AT_END; w.stay = 1'b1;
        w.target = S_EMIT;
      end
      S_SKIP: begin
        w.set_skip = 1'b1; w.cond = C_ALWAYS; w.target = S_EMIT;
      end
      S_WRITE: begin
        w.plot = 1'b1; w.cond = C_ALWAYS; w.target = S_EMIT;
      end
      S_READ: begin
        w.rd_issue = 1'b1; w.cond = C_NEVER; w.target = S_READ_WAIT;
      end
      S_READ_WAIT: begin
        w.cond = C_NEVER; w.target = S_READ_TAKE;
      end
      S_READ_TAKE: begin
        w.take_rd = 1'b1; w.cond = C_ALWAYS; w.target = S_EMIT;
      end
      S_EMIT: begin
        w.emit = 1'b1; w.cond = C_OUT_FREE; w.stay = 1'b1; w.target = S_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/char_grid_line_drawer_unit.sv
// ----------------------------------------------------------------------------
// char_grid_line_drawer_unit
// Character cell frame store with a line drawer, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// usage
//   s_axis takes one command item (draw line, write cell, read cell); m_axis
//   returns one result item per command. cfg_* writes screen width (index 0)
//   and screen height (index 1); it is always ready.
//   one item at a time; the draw step plots the points of the line in turn,
//   and a draw with both ends off screen is skipped. the next item can be
//   taken in the cycle after the result is loaded into the output register,
//   so a result waiting there does not hold up the input side.
//   the cell memory has one port; each point is one memory write.
//   after reset all MAX_COLUMNS * MAX_ROWS cells are swept to spaces, one
//   cell per cycle, with s_axis_tready low.
//   a stalled result stays in the output register until taken; the next
//   command is still accepted and runs up to its result step.
// ----------------------------------------------------------------------------
module char_grid_line_drawer_unit #(
  parameter int MAX_COLUMNS = cgld_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = cgld_pkg::MAX_ROWS_DEF,
  parameter int GLYPH_BITS  = cgld_pkg::GLYPH_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // start_x, start_y, end_x, end_y (11 bits each), glyph (32), zero fill
  input  logic [cgld_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // command
  input  logic [cgld_pkg::CMD_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // cell_value
  output logic [cgld_pkg::VALUE_W-1:0]      m_axis_tdata,
  // line_skipped
  output logic                              m_axis_tuser,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cgld_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cgld_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import cgld_pkg::*;

  localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_BITS  = $clog2(CELL_COUNT);
  localparam int COL_BITS   = $clog2(MAX_COLUMNS);
  localparam int ROW_BITS   = $clog2(MAX_ROWS);
  localparam int WC_BITS    = $clog2(MAX_COLUMNS + 1);
  localparam int PROD_W     = ROW_BITS + WC_BITS + 1;
  localparam logic signed [11:0] MAX_COL_S = 12'(MAX_COLUMNS);
  localparam logic signed [11:0] MAX_ROW_S = 12'(MAX_ROWS);
  localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(CELL_COUNT - 1);
  localparam logic [GLYPH_BITS-1:0] SPACE_G = SPACE_CODE[GLYPH_BITS-1:0];

  function automatic logic signed [11:0] clamp_lim(input logic signed [11:0] v,
                                                   input logic signed [11:0] lim);
    logic signed [11:0] r;
    if (v < 12'sd0) begin
      r = 12'sd0;
    end else if (v >= lim) begin
      r = lim - 12'sd1;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // sequencer and control
  step_t                 step_q, step_d;
  ucode_t                uc;
  logic                  cond_true;
  logic [ADDR_BITS-1:0]  clr_q;
  logic [WIDTH_W-1:0]    width_q;
  logic [HEIGHT_W-1:0]   height_q;
  logic                  mem_we_q;
  logic                  out_valid_q;
  logic                  out_free;
  logic                  in_take;

  // datapath
  logic [CMD_W-1:0]      cmd_q;
  logic signed [11:0]    cur_x_q, cur_y_q, end_x_q, end_y_q;
  logic signed [12:0]    dx_q, dy_q;
  logic                  x_down_q, y_down_q;
  logic signed [14:0]    err_q;
  logic [GLYPH_BITS-1:0] glyph_q;
  logic [VALUE_W-1:0]    res_value_q;
  logic                  res_skip_q;
  logic [VALUE_W-1:0]    out_value_q;
  logic                  out_skip_q;

  // memory
  logic [GLYPH_BITS-1:0] mem [CELL_COUNT];
  logic [ADDR_BITS-1:0]  mem_addr_q;
  logic [GLYPH_BITS-1:0] mem_wdata_q;
  logic [GLYPH_BITS-1:0] rd_data_q;

  // input unpacking
  logic signed [11:0]    in_sx, in_sy, in_ex, in_ey;
  logic signed [12:0]    diff_x, diff_y;
  logic [63:0]           glyph_wide;
  logic [63:0]           rd_wide;

  // geometry
  logic signed [11:0]    w_ext, h_ext, eff_w, eff_h;
  logic signed [11:0]    col_c, row_c;
  logic [COL_BITS-1:0]   col;
  logic [ROW_BITS-1:0]   row;
  logic [PROD_W-1:0]     idx_wide;
  logic [ADDR_BITS-1:0]  cell_addr;
  logic                  start_on, end_on, both_off, at_end;

  // bresenham step
  logic signed [15:0]    twice, dx16, dy16;
  logic signed [14:0]    dx15, dy15;
  logic                  step_x, step_y;
  logic signed [14:0]    err_d;

  assign uc            = ucode_rom(step_q);
  assign s_axis_tready = uc.accept;
  assign in_take       = s_axis_tvalid & uc.accept;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_skip_q;

  assign in_sx  = {s_axis_tdata[10], s_axis_tdata[10:0]};
  assign in_sy  = {s_axis_tdata[21], s_axis_tdata[21:11]};
  assign in_ex  = {s_axis_tdata[32], s_axis_tdata[32:22]};
  assign in_ey  = {s_axis_tdata[43], s_axis_tdata[43:33]};
  assign diff_x = {in_ex[11], in_ex} - {in_sx[11], in_sx};
  assign diff_y = {in_ey[11], in_ey} - {in_sy[11], in_sy};
  assign glyph_wide = 64'(s_axis_tdata[75:44]);
  assign rd_wide    = 64'(rd_data_q);

  // effective screen size, out of range registers pulled into range
  assign w_ext = $signed({4'b0, width_q});
  assign h_ext = $signed({5'b0, height_q});
  always_comb begin
    if (w_ext == 12'sd0) begin
      eff_w = 12'sd1;
    end else if (w_ext > MAX_COL_S) begin
      eff_w = MAX_COL_S;
    end else begin
      eff_w = w_ext;
    end
    if (h_ext == 12'sd0) begin
      eff_h = 12'sd1;
    end else if (h_ext > MAX_ROW_S) begin
      eff_h = MAX_ROW_S;
    end else begin
      eff_h = h_ext;
    end
  end

  assign col_c     = clamp_lim(cur_x_q, eff_w);
  assign row_c     = clamp_lim(cur_y_q, eff_h);
  assign col       = col_c[COL_BITS-1:0];
  assign row       = row_c[ROW_BITS-1:0];
  assign idx_wide  = PROD_W'(row) * PROD_W'(eff_w[WC_BITS-1:0]) + PROD_W'(col);
  assign cell_addr = idx_wide[ADDR_BITS-1:0];

  assign start_on = (cur_x_q >= 12'sd0) && (cur_x_q < eff_w) &&
                    (cur_y_q >= 12'sd0) && (cur_y_q < eff_h);
  assign end_on   = (end_x_q >= 12'sd0) && (end_x_q < eff_w) &&
                    (end_y_q >= 12'sd0) && (end_y_q < eff_h);
  assign both_off = ~start_on & ~end_on;
  assign at_end   = (cur_x_q == end_x_q) && (cur_y_q == end_y_q);

  assign dx15   = {{2{dx_q[12]}}, dx_q};
  assign dy15   = {{2{dy_q[12]}}, dy_q};
  assign dx16   = {{3{dx_q[12]}}, dx_q};
  assign dy16   = {{3{dy_q[12]}}, dy_q};
  assign twice  = {err_q, 1'b0};
  assign step_x = twice > -dy16;
  assign step_y = twice < dx16;
  assign err_d  = err_q - (step_x ? dy15 : 15'sd0) + (step_y ? dx15 : 15'sd0);

  always_comb begin
    case (uc.cond)
      C_NEVER:      cond_true = 1'b0;
      C_ALWAYS:     cond_true = 1'b1;
      C_ACCEPT:     cond_true = in_take;
      C_CMD_DRAW:   cond_true = (cmd_q == CMD_DRAW);
      C_CMD_WRITE:  cond_true = (cmd_q == CMD_WRITE);
      C_CMD_READ:   cond_true = (cmd_q == CMD_READ);
      C_BOTH_OFF:   cond_true = both_off;
      C_AT_END:     cond_true = at_end;
      C_CLEAR_LAST: cond_true = (clr_q == LAST_ADDR);
      C_OUT_FREE:   cond_true = out_free;
      default:      cond_true = 1'b0;
    endcase
    if (cond_true) begin
      step_d = uc.target;
    end else if (uc.stay) begin
      step_d = step_q;
    end else begin
      step_d = step_q + step_t'(1);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= S_CLEAR;
      clr_q       <= '0;
      width_q     <= WIDTH_RST;
      height_q    <= HEIGHT_RST;
      mem_we_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q   <= step_d;
      mem_we_q <= uc.clear_wr | uc.plot;
      if (uc.clear_wr) begin
        clr_q <= clr_q + ADDR_BITS'(1);
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_WIDTH:  width_q  <= cfg_data_i;
          REG_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
          default:    ;
        endcase
      end
      if (uc.emit && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q       <= s_axis_tuser;
      cur_x_q     <= in_sx;
      cur_y_q     <= in_sy;
      end_x_q     <= in_ex;
      end_y_q     <= in_ey;
      dx_q        <= diff_x[12] ? -diff_x : diff_x;
      dy_q        <= diff_y[12] ? -diff_y : diff_y;
      x_down_q    <= ~(in_sx < in_ex);
      y_down_q    <= ~(in_sy < in_ey);
      glyph_q     <= glyph_wide[GLYPH_BITS-1:0];
      res_value_q <= '0;
      res_skip_q  <= 1'b0;
    end
    if (uc.init_err) begin
      err_q <= dx15 - dy15;
    end
    if (uc.brs_step && !at_end) begin
      err_q <= err_d;
      if (step_x) begin
        cur_x_q <= x_down_q ? cur_x_q - 12'sd1 : cur_x_q + 12'sd1;
      end
      if (step_y) begin
        cur_y_q <= y_down_q ? cur_y_q - 12'sd1 : cur_y_q + 12'sd1;
      end
    end
    if (uc.set_skip) begin
      res_skip_q <= 1'b1;
    end
    if (uc.take_rd) begin
      res_value_q <= rd_wide[VALUE_W-1:0];
    end
    if (uc.clear_wr) begin
      mem_addr_q  <= clr_q;
      mem_wdata_q <= SPACE_G;
    end else if (uc.plot || uc.rd_issue) begin
      mem_addr_q  <= cell_addr;
      mem_wdata_q <= glyph_q;
    end
    if (uc.emit && out_free) begin
      out_value_q <= res_value_q;
      out_skip_q  <= res_skip_q;
    end
  end

  // cell memory, one port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we_q) begin
      mem[mem_addr_q] <= mem_wdata_q;
    end
    rd_data_q <= mem[mem_addr_q];
  end

  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_CLEAR) |-> !s_axis_tready)
    else $error("item taken during clearing sweep");

  a_mem_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_q |-> ($past(step_q) == S_CLEAR || $past(step_q) == S_DRAW ||
                  $past(step_q) == S_WRITE))
    else $error("memory write from unexpected step");

  a_skip_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("skipped line carries a cell value");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(step_q) == S_EMIT))
    else $error("result raised outside result step");

endmodule

### tb/char_grid_line_drawer_unit_tb.sv
// ----------------------------------------------------------------------------
// char_grid_line_drawer_unit_tb
// Drives line, cell write and cell read commands into the character grid and
// checks every result against an in-bench model of the grid or a fixed value.
// A directed table covers coordinate extremes, clamping, skipped lines and the
// unused command. Randomised commands follow under several screen geometries,
// with random stalls on both streams in every phase but the quiet one.
// ----------------------------------------------------------------------------
module char_grid_line_drawer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cgld_pkg::*;

  localparam int GRID_CELLS = MAX_COLUMNS_DEF * MAX_ROWS_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 82;
  localparam int QUIET_PHASE = 3;
  localparam int SETTLE_CYCLES = 16;
  // clear sweep plus every item as the longest line with stalls, several times
  localparam int CYCLE_LIMIT = 6_000_000;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    coord_t           sx;
    coord_t           sy;
    coord_t           ex;
    coord_t           ey;
    logic [31:0]      glyph;
  } grid_cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0] cell_value;
    logic               line_skipped;
  } grid_result_t;

  typedef struct packed {
    grid_cmd_t    item;
    logic         fixed;
    grid_result_t want;
  } probe_row_t;

  localparam int PROBE_ROWS = 24;
  localparam probe_row_t PROBES [PROBE_ROWS] = '{
    '{'{CMD_READ, 11'sd0, 11'sd0, 11'sd0, 11'sd0, 32'h0}, 1'b1, '{32'h20, 1'b0}},
    '{'{CMD_READ, -11'sd1024, -11'sd1024, 11'sd1023, 11'sd1023, 32'hFFFF_FFFF},
      1'b1, '{32'h20, 1'b0}},
    '{'{CMD_READ, 11'sd1023, 11'sd1023, 11'sd0, 11'sd0, 32'h0}, 1'b1, '{32'h20, 1'b0}},
    '{'{CMD_WRITE, 11'sd5, 11'sd3, 11'sd0, 11'sd0, 32'hFFFF_FFFF}, 1'b1, '{32'h0, 1'b0}},
    '{'{CMD_READ, 11'sd5, 11'sd3, 11'sd0, 11'sd0, 32'h0}, 1'b1, '{32'hFFFF_FFFF, 1'b0}},
    '{'{CMD_WRITE, -11'sd1024, 11'sd1023, 11'sd0, 11'sd0, 32'h0}, 1'b1, '{32'h0, 1'b0}},
    '{'{CMD_READ, -11'sd5, 11'sd30, 11'sd0, 11'sd0, 32'h0}, 1'b1, '{32'h0, 1'b0}},
    '{'{CMD_DRAW, -11'sd1024, -11'sd1024, 11'sd1023, 11'sd1023, 32'h2A},
      1'b1, '{32'h0, 1'b1}},
    '{'{CMD_DRAW, -11'sd1, -11'sd1, -11'sd5, 11'sd100, 32'h2B}, 1'b1, '{32'h0, 1'b1}},
    '{'{CMD_DRAW, 11'sd0, 11'sd0, 11'sd79, 11'sd23, 32'h41}, 1'b0, '0},
    '{'{CMD_READ, 11'sd40, 11'sd12, 11'sd0, 11'sd0, 32'h0}, 1'b0, '0},
    '{'{CMD_DRAW, 11'sd10, 11'sd10, 11'sd10, 11'sd10, 32'h42}, 1'b0, '0},
    '{'{CMD_DRAW, 11'sd70, 11'sd20, 11'sd200, -11'sd50, 32'h00E2_9688}, 1'b0, '0},
    '{'{CMD_READ, 11'sd79, 11'sd0, 11'sd0, 11'sd0, 32'h0}, 1'b0, '0},
    '{'{CMD_DRAW, 11'sd3, 11'sd23, 11'sd1, 11'sd0, 32'h43}, 1'b0, '0},
    '{'{CMD_DRAW, 11'sd79, 11'sd5, 11'sd0, 11'sd5, 32'h44}, 1'b0, '0},
    '{'{CMD_READ, 11'sd0, 11'sd5, 11'sd0, 11'sd0, 32'h0}, 1'b0, '0},
    '{'{CMD_UNUSED, 11'sd12, 11'sd7, -11'sd3, 11'sd9, 32'hDEAD_BEEF}, 1'b1, '{32'h0, 1'b0}},
    '{'{CMD_UNUSED, -11'sd1024, 11'sd1023, -11'sd1024, 11'sd1023, 32'hFFFF_FFFF},
      1'b1, '{32'h0, 1'b0}},
    '{'{CMD_READ, 11'sd79, 11'sd23, 11'sd0, 11'sd0, 32'h0}, 1'b0, '0},
    '{'{CMD_DRAW, 11'sd0, 11'sd0, -11'sd1024, 11'sd1023, 32'h55AA_55AA}, 1'b0, '0},
    '{'{CMD_READ, 11'sd0, 11'sd23, 11'sd0, 11'sd0, 32'h0}, 1'b0, '0},
    '{'{CMD_WRITE, 11'sd1023, -11'sd1024, 11'sd0, 11'sd0, 32'h1234_5678},
      1'b1, '{32'h0, 1'b0}},
    '{'{CMD_READ, 11'sd79, 11'sd0, 11'sd0, 11'sd0, 32'h0}, 1'b1, '{32'h1234_5678, 1'b0}}
  };

  localparam logic [7:0] PHASE_WIDTH  [PHASES] = '{8'd128, 8'd1, 8'd0, 8'd255,
                                                   8'd37, 8'd200, 8'd0, 8'd80};
  localparam logic [7:0] PHASE_HEIGHT [PHASES] = '{8'd64, 8'd1, 8'd0, 8'd255,
                                                   8'd9, 8'd100, 8'd0, 8'd24};

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  // start_x, start_y, end_x, end_y (11 bits each), glyph (32), zero fill
  logic [IN_DATA_W-1:0] s_axis_tdata;
  // command
  logic [CMD_W-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // cell_value
  logic [VALUE_W-1:0] m_axis_tdata;
  // line_skipped
  logic m_axis_tuser;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  logic [31:0] grid_cells [GRID_CELLS];
  logic [WIDTH_W-1:0] cols_reg;
  logic [HEIGHT_W-1:0] rows_reg;
  grid_result_t pending_results [$];

  bit idle_on = 1'b1;
  int fail_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int draws_sent = 0;
  int reads_sent = 0;
  int skips_seen = 0;
  int results_seen = 0;

  char_grid_line_drawer_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // screen model

  function automatic int grid_cols();
    if (cols_reg == 0) return 1;
    if (int'(cols_reg) > MAX_COLUMNS_DEF) return MAX_COLUMNS_DEF;
    return int'(cols_reg);
  endfunction

  function automatic int grid_rows();
    if (rows_reg == 0) return 1;
    if (int'(rows_reg) > MAX_ROWS_DEF) return MAX_ROWS_DEF;
    return int'(rows_reg);
  endfunction

  function automatic int clamp_coord(int v, int span);
    if (v < 0) return 0;
    if (v >= span) return span - 1;
    return v;
  endfunction

  function automatic int cell_at(int x, int y);
    int idx;
    idx = clamp_coord(y, grid_rows()) * grid_cols() + clamp_coord(x, grid_cols());
    if (idx >= GRID_CELLS) idx = GRID_CELLS - 1;
    return idx;
  endfunction

  function automatic bit on_grid(int x, int y);
    return x >= 0 && x < grid_cols() && y >= 0 && y < grid_rows();
  endfunction

  // returns 0 when the line is dropped for both ends being off screen
  function automatic bit trace_line(int x0, int y0, int x1, int y1, logic [31:0] g);
    int dx, dy, step_x, step_y, err, twice;
    if (!on_grid(x0, y0) && !on_grid(x1, y1)) return 1'b0;
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    step_x = (x0 < x1) ? 1 : -1;
    step_y = (y0 < y1) ? 1 : -1;
    err = dx - dy;
    while (1) begin
      grid_cells[cell_at(x0, y0)] = g;
      if (x0 == x1 && y0 == y1) break;
      twice = 2 * err;
      if (twice > -dy) begin
        err -= dy;
        x0 += step_x;
      end
      if (twice < dx) begin
        err += dx;
        y0 += step_y;
      end
    end
    return 1'b1;
  endfunction

  function automatic grid_result_t apply_command(grid_cmd_t it);
    grid_result_t r;
    r = '0;
    case (it.cmd)
      CMD_DRAW:  r.line_skipped = !trace_line(it.sx, it.sy, it.ex, it.ey, it.glyph);
      CMD_WRITE: grid_cells[cell_at(it.sx, it.sy)] = it.glyph;
      CMD_READ:  r.cell_value = grid_cells[cell_at(it.sx, it.sy)];
      default: ;
    endcase
    return r;
  endfunction

  // stimulus helpers

  task automatic issue_command(input grid_cmd_t it, input bit fixed,
                               input grid_result_t fixed_res);
    grid_result_t r;
    while (idle_on && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, it.glyph, it.ey, it.ex, it.sy, it.sx};
    s_axis_tuser  <= it.cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = apply_command(it);
    pending_results.push_back(fixed ? fixed_res : r);
    items_sent++;
    if (it.cmd == CMD_DRAW) draws_sent++;
    if (it.cmd == CMD_READ) reads_sent++;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_WIDTH) cols_reg = val;
    else if (idx == REG_HEIGHT) rows_reg = val[HEIGHT_W-1:0];
  endtask

  function automatic coord_t pick_coord(int span);
    if ($urandom_range(0, 9) == 0) return coord_t'(int'($urandom_range(0, 2047)) - 1024);
    return coord_t'(int'($urandom_range(0, span + 7)) - 4);
  endfunction

  function automatic grid_cmd_t random_command();
    grid_cmd_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 38) it.cmd = CMD_DRAW;
    else if (pick < 68) it.cmd = CMD_WRITE;
    else if (pick < 96) it.cmd = CMD_READ;
    else it.cmd = CMD_UNUSED;
    it.sx = pick_coord(grid_cols());
    it.sy = pick_coord(grid_rows());
    it.ex = pick_coord(grid_cols());
    it.ey = pick_coord(grid_rows());
    it.glyph = $urandom;
    return it;
  endfunction

  // result side

  always @(posedge clk_i) begin : result_monitor
    grid_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tuser) skips_seen++;
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: result with none expected, actual value %h skipped %b",
                 $time, m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.cell_value) begin
          fail_count++;
          $display("%0t: cell_value expected %h actual %h",
                   $time, want.cell_value, m_axis_tdata);
        end
        if (m_axis_tuser !== want.line_skipped) begin
          fail_count++;
          $display("%0t: line_skipped expected %b actual %b",
                   $time, want.line_skipped, m_axis_tuser);
        end
      end
    end
    m_axis_tready <= !idle_on || ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    grid_cmd_t it;
    logic [7:0] w_data, h_data;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    cols_reg      = WIDTH_RST;
    rows_reg      = HEIGHT_RST;
    foreach (grid_cells[i]) grid_cells[i] = SPACE_CODE[31:0];
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < PROBE_ROWS; i++)
      issue_command(PROBES[i].item, PROBES[i].fixed, PROBES[i].want);

    for (int p = 0; p < PHASES; p++) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      w_data = PHASE_WIDTH[p];
      h_data = PHASE_HEIGHT[p];
      if (p == 6) begin
        w_data = $urandom_range(1, 128);
        h_data = $urandom_range(1, 64);
      end
      write_reg(REG_WIDTH, w_data);
      write_reg(REG_HEIGHT, h_data);
      // writes to unmapped indexes must leave the geometry alone
      if (p == 1 || p == 5) begin
        write_reg(REG_SPARE_A, $urandom_range(0, 255));
        write_reg(REG_SPARE_B, $urandom_range(0, 255));
      end
      cfg_valid_i <= 1'b0;
      idle_on = (p != QUIET_PHASE);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        it = random_command();
        issue_command(it, 1'b0, '0);
        if (i % 40 == 39) begin
          s_axis_tvalid <= 1'b0;
          @(posedge clk_i);
          wait_drained();
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d commands (%0d line draws, %0d reads), %0d results, %0d skipped lines",
             items_sent, draws_sent, reads_sent, results_seen, skips_seen);
    $display("over %0d screen geometries after the reset one, %0d mismatches",
             PHASES, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/cgld_pkg.sv
rtl/char_grid_line_drawer_unit.sv
tb/char_grid_line_drawer_unit_tb.sv
